// ----- hdl/mfv_pkg.sv -----
// Shared types and constants for the most frequent value finder.
package mfv_pkg;

    localparam int VALUE_W   = 32;
    localparam int MCOUNT_W  = 7;
    localparam int QDEPTH    = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               store;
        logic               close;
        logic               ovf;
    } req_t;

    typedef enum logic [2:0] {
        B_LOAD,
        B_CAND,
        B_SCAN,
        B_EVAL,
        B_OUT
    } back_state_t;

endpackage

// ----- hdl/mfv_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module mfv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hdl/mfv_queue.sv -----
// Short request queue between the front and back parts.
module mfv_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mfv_pkg::req_t push_req,
    output logic          full,
    input  logic          pop,
    output mfv_pkg::req_t pop_req,
    output logic          empty
);

    localparam int PTR_W = (mfv_pkg::QDEPTH > 1) ? $clog2(mfv_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(mfv_pkg::QDEPTH + 1);

    mfv_pkg::req_t    entry_reg [mfv_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(mfv_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_req = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mfv_pkg::QDEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mfv_pkg::QDEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push && !full) - CNT_W'(pop && !empty);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ----- hdl/mfv_front.sv -----
// Front part: accepts input requests, drops overflow elements, marks set close.
module mfv_front #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mfv_pkg::VALUE_W-1:0]   s_tdata,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          push,
    output mfv_pkg::req_t                 push_req
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);

    logic [CNT_W-1:0] fcount_reg, fcount_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             room;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign room     = (fcount_reg < CNT_W'(STORE_DEPTH));

    always_comb begin
        push_req.value = s_tdata;
        push_req.store = room;
        push_req.close = s_tlast;
        push_req.ovf   = ovf_reg || !room;
        push           = accept && (room || s_tlast);
    end

    always_comb begin
        fcount_next = fcount_reg;
        ovf_next    = ovf_reg;
        if (accept) begin
            if (s_tlast) begin
                fcount_next = '0;
                ovf_next    = 1'b0;
            end else if (room) begin
                fcount_next = fcount_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcount_reg <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            fcount_reg <= fcount_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// ----- hdl/mfv_back.sv -----
// Back part: stores elements, runs the counting pass and holds the result.
module mfv_back #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  mfv_pkg::req_t                  pop_req,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mfv_pkg::VALUE_W-1:0]    mode_value,
    output logic [mfv_pkg::MCOUNT_W-1:0]   mode_count,
    output logic                           overflow
);

    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    mfv_pkg::back_state_t state_reg, state_next;

    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            i_reg, i_next;
    logic [CNT_W-1:0]            j_reg, j_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            best_cnt_reg, best_cnt_next;
    logic [mfv_pkg::VALUE_W-1:0] best_val_reg, best_val_next;
    logic                        ovf_reg, ovf_next;
    logic                        pend_reg, pend_next;

    logic                        we;
    logic [mfv_pkg::VALUE_W-1:0] cand;
    logic [mfv_pkg::VALUE_W-1:0] probe;
    logic                        better;
    logic                        last_cand;

    mfv_ram #(
        .WIDTH (mfv_pkg::VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (n_reg[ADDR_W-1:0]),
        .wdata   (pop_req.value),
        .raddr_a (i_reg[ADDR_W-1:0]),
        .rdata_a (cand),
        .raddr_b (j_reg[ADDR_W-1:0]),
        .rdata_b (probe)
    );

    assign better = (cnt_reg > best_cnt_reg) ||
                    ((cnt_reg == best_cnt_reg) && ($signed(cand) < $signed(best_val_reg)));
    assign last_cand = ((i_reg + 1'b1) == n_reg);

    assign mode_value = best_val_reg;
    assign mode_count = mfv_pkg::MCOUNT_W'(best_cnt_reg);
    assign overflow   = ovf_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mfv_pkg::B_LOAD: begin
                if (!q_empty && pop_req.close) begin
                    state_next = mfv_pkg::B_CAND;
                end
            end
            mfv_pkg::B_CAND: state_next = mfv_pkg::B_SCAN;
            mfv_pkg::B_SCAN: begin
                if (j_reg == n_reg) begin
                    state_next = mfv_pkg::B_EVAL;
                end
            end
            mfv_pkg::B_EVAL: state_next = last_cand ? mfv_pkg::B_OUT : mfv_pkg::B_CAND;
            mfv_pkg::B_OUT: begin
                if (m_tready) begin
                    state_next = mfv_pkg::B_LOAD;
                end
            end
            default: state_next = mfv_pkg::B_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        pop      = (state_reg == mfv_pkg::B_LOAD) && !q_empty;
        we       = pop && pop_req.store;
        m_tvalid = (state_reg == mfv_pkg::B_OUT);
    end

    // datapath
    always_comb begin
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        ovf_next      = ovf_reg;
        pend_next     = 1'b0;
        unique case (state_reg)
            mfv_pkg::B_LOAD: begin
                if (pop) begin
                    if (pop_req.store) begin
                        n_next = n_reg + 1'b1;
                    end
                    if (pop_req.close) begin
                        ovf_next      = pop_req.ovf;
                        i_next        = '0;
                        best_cnt_next = '0;
                        best_val_next = '0;
                    end
                end
            end
            mfv_pkg::B_CAND: begin
                j_next   = '0;
                cnt_next = '0;
            end
            mfv_pkg::B_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(pend_reg && (probe == cand));
                if (j_reg != n_reg) begin
                    j_next    = j_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            mfv_pkg::B_EVAL: begin
                if (better) begin
                    best_cnt_next = cnt_reg;
                    best_val_next = cand;
                end
                i_next = i_reg + 1'b1;
            end
            mfv_pkg::B_OUT: begin
                if (m_tready) begin
                    n_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfv_pkg::B_LOAD;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        cnt_reg      <= cnt_next;
        best_cnt_reg <= best_cnt_next;
        best_val_reg <= best_val_next;
        ovf_reg      <= ovf_next;
    end

endmodule

// ----- hdl/most_frequent_value_finder.sv -----
// Top level of the most frequent value finder.
//
// Input stream: one signed 32-bit element per request; tlast closes the set.
// Elements beyond STORE_DEPTH are dropped and flagged as overflow.
// Output stream: one request per closed set carrying the most frequent value
// (smallest among ties), its count and the overflow flag.
// Elements are loaded into the element RAM through a two-entry request queue.
// After the closing element the counting pass reads the element RAM with two
// read ports, taking each stored element in turn as the candidate and counting
// its matches among all stored elements; tvalid rises when the pass ends.
// While the pass runs or a result waits, the front keeps taking elements of
// the next set until the queue fills, then drops tready.
// A stalled result holds its value until m_tready. Reset (aresetn low,
// synchronous) empties the queue and the set; stored RAM data is not cleared.
module most_frequent_value_finder #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mfv_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mfv_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] mode_value, [38:32] mode_count
    output logic                            m_tuser    // [0] overflow
);

    logic                          q_full;
    logic                          q_empty;
    logic                          push;
    logic                          pop;
    mfv_pkg::req_t                 push_req;
    mfv_pkg::req_t                 pop_req;
    logic [mfv_pkg::VALUE_W-1:0]   mode_value;
    logic [mfv_pkg::MCOUNT_W-1:0]  mode_count;

    mfv_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_req (push_req)
    );

    mfv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (pop),
        .pop_req  (pop_req),
        .empty    (q_empty)
    );

    mfv_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .pop_req    (pop_req),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .mode_value (mode_value),
        .mode_count (mode_count),
        .overflow   (m_tuser)
    );

    assign m_tdata = {1'b0, mode_count, mode_value};

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the most frequent value finder: directed table, then random sets.
`timescale 1ns / 1ps

module tb_top;

    localparam int          DEPTH        = 64;
    localparam int          RANDOM_ITEMS = 830;
    localparam int          N_DIRECTED   = 19;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
    localparam logic [31:0] VAL_NEG1     = 32'hffff_ffff;

    typedef struct packed {
        logic [mfv_pkg::VALUE_W-1:0]  value;
        logic [mfv_pkg::MCOUNT_W-1:0] count;
        logic                         ovf;
    } mode_t;

    typedef struct packed {
        logic [mfv_pkg::VALUE_W-1:0] value;
        logic                        last;
        logic                        pinned;
        mode_t                       want;
    } row_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mfv_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mfv_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;

    // set image held by the predictor
    logic [mfv_pkg::VALUE_W-1:0] set_store [DEPTH];
    int                          set_fill    = 0;
    logic                        set_dropped = 1'b0;

    mode_t mode_q [$];
    int    err_cnt    = 0;
    int    burst_left = 0;
    int    stall_cyc  = 0;
    int    stall_mode = 0;

    row_t directed_rows [0:N_DIRECTED-1] = '{
        '{VAL_MIN,      1'b1, 1'b1, '{VAL_MIN,  7'd1, 1'b0}},
        '{VAL_MAX,      1'b1, 1'b1, '{VAL_MAX,  7'd1, 1'b0}},
        '{32'd0,        1'b1, 1'b1, '{32'd0,    7'd1, 1'b0}},
        '{VAL_NEG1,     1'b1, 1'b1, '{VAL_NEG1, 7'd1, 1'b0}},
        '{VAL_MAX,      1'b0, 1'b0, '0},
        '{VAL_MIN,      1'b1, 1'b1, '{VAL_MIN,  7'd1, 1'b0}},
        '{32'd7,        1'b0, 1'b0, '0},
        '{-32'sd3,      1'b0, 1'b0, '0},
        '{32'd7,        1'b0, 1'b0, '0},
        '{-32'sd3,      1'b0, 1'b0, '0},
        '{32'd5,        1'b1, 1'b0, '0},
        '{32'h5555_5555, 1'b0, 1'b0, '0},
        '{32'haaaa_aaaa, 1'b0, 1'b0, '0},
        '{32'h5555_5555, 1'b0, 1'b0, '0},
        '{32'haaaa_aaaa, 1'b1, 1'b0, '0},
        '{32'd9,        1'b0, 1'b0, '0},
        '{32'd9,        1'b0, 1'b0, '0},
        '{32'd9,        1'b0, 1'b0, '0},
        '{-32'sd9,      1'b1, 1'b0, '0}
    };

    most_frequent_value_finder #(
        .STORE_DEPTH(DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] mode_value, [38:32] mode_count
        .m_tuser  (m_tuser)    // [0] overflow
    );

    always #5 aclk = ~aclk;

    function automatic mode_t tally_mode();
        mode_t                        best;
        logic [mfv_pkg::MCOUNT_W-1:0] n;
        best = '0;
        for (int i = 0; i < set_fill; i++) begin
            n = '0;
            for (int j = 0; j < set_fill; j++) begin
                if (set_store[j] == set_store[i]) n++;
            end
            if (n > best.count ||
                (n == best.count && $signed(set_store[i]) < $signed(best.value))) begin
                best.count = n;
                best.value = set_store[i];
            end
        end
        best.ovf = set_dropped;
        return best;
    endfunction

    task automatic absorb_element(input logic [31:0] v, input logic l,
                                  output logic closes, output mode_t res);
        if (set_fill < DEPTH) begin
            set_store[set_fill] = v;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        closes = l;
        res    = '0;
        if (l) begin
            res         = tally_mode();
            set_fill    = 0;
            set_dropped = 1'b0;
        end
    endtask

    function automatic int next_burst();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    endfunction

    task automatic send_item(input logic [31:0] v, input logic l,
                             input logic pinned, input mode_t want);
        logic  closes;
        mode_t got;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        absorb_element(v, l, closes, got);
        if (closes) mode_q.push_back(pinned ? want : got);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = next_burst();
        end
    endtask

    // hold off until every pending result has come back
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (mode_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 256 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= stall_cyc[2];
        endcase
    end

    always @(posedge aclk) begin
        mode_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (mode_q.size() == 0) begin
                $error("unexpected result: mode_value %h", m_tdata[31:0]);
                err_cnt++;
            end else begin
                exp_r = mode_q.pop_front();
                if (m_tdata[31:0] !== exp_r.value) begin
                    $error("mode_value: expected %h, got %h", exp_r.value, m_tdata[31:0]);
                    err_cnt++;
                end
                if (m_tdata[38:32] !== exp_r.count) begin
                    $error("mode_count: expected %0d, got %0d", exp_r.count, m_tdata[38:32]);
                    err_cnt++;
                end
                if (m_tuser !== exp_r.ovf) begin
                    $error("overflow: expected %b, got %b", exp_r.ovf, m_tuser);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int               sent;
        int               set_idx;
        int               size;
        int               flavor;
        logic [31:0]      pool [4];
        logic [31:0]      v;
        logic [31:0]      corner [5];
        corner = '{VAL_MIN, VAL_MAX, 32'd0, VAL_NEG1, 32'd1};
        burst_left = next_burst();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].pinned, directed_rows[r].want);
        end
        drain_wait();

        sent    = 0;
        set_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            if (set_idx == 10 || set_idx == 40) size = DEPTH + $urandom_range(1, 6);
            else if (set_idx == 25)             size = DEPTH;
            else                                size = $urandom_range(1, 12);
            if (size >= DEPTH || $urandom_range(0, 19) == 0) drain_wait();
            flavor = $urandom_range(0, 3);
            foreach (pool[p]) pool[p] = $urandom();
            for (int k = 0; k < size; k++) begin
                case (flavor)
                    0: v = pool[$urandom_range(0, 3)];
                    1: v = $urandom();
                    2: v = 32'($urandom_range(0, 8)) - 32'd4;
                    default: v = corner[$urandom_range(0, 4)];
                endcase
                send_item(v, k == size - 1, 1'b0, '0);
                sent++;
            end
            set_idx++;
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (mode_q.size() != 0);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
